// File: rtl/core/nco_complex_mixer_assert.svh
// Assertion macros for the NCO mixer checks.
`ifndef NCO_COMPLEX_MIXER_ASSERT_SVH
`define NCO_COMPLEX_MIXER_ASSERT_SVH

// Checked only outside reset.
`define NCM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked at every edge, reset included.
`define NCM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/ncm_pkg.sv
package ncm_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int AMP_BITS      = 15;
    localparam int CFG_DATA_BITS = 16;
    localparam int STEP_BITS     = 16;
    localparam int PROD_BITS     = 2 * SAMPLE_BITS;
    localparam int SUM_BITS      = 2 * SAMPLE_BITS + 1;
    localparam int MAG_BITS      = 2 * SAMPLE_BITS - 1;
    localparam int QUOT_BITS     = SAMPLE_BITS + 1;
    localparam int PIPE_DEPTH    = 5;
    localparam int CNT_BITS      = $clog2(PIPE_DEPTH + 1);

    // x / 32767 == (x * (2^31 + 2^16 + 3)) >> 46 for x < 2^31
    localparam int RECIP_SHIFT_HI = 31;
    localparam int RECIP_SHIFT_LO = 16;
    localparam int RECIP_ADD      = 3;
    localparam int RECIP_SHIFT    = 46;

    localparam logic [63:0] PIH_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
    localparam logic [63:0] AMP     = 64'd32767;
    localparam int TAYLOR_TERMS     = 10;
    localparam logic [63:0] TAYLOR_DIV [1:10] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
          64'd156, 64'd210, 64'd272, 64'd342, 64'd420};

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [PROD_BITS-1:0]   prod_t;
    typedef logic signed [SUM_BITS-1:0]    sum_t;
    typedef logic [MAG_BITS-1:0]           mag_t;
    typedef logic [QUOT_BITS-1:0]          quot_t;
    typedef logic [AMP_BITS-1:0]           amp_t;

    typedef enum logic [0:0] {
        REG_MIX_ENABLE = 1'b0,
        REG_PHASE_STEP = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        sample_t in_i;
        sample_t in_q;
    } in_word_t;

    typedef struct packed {
        sample_t out_i;
        sample_t out_q;
    } out_word_t;

    // Quarter-wave sine entry j of a table with 2^addr_bits entries, unsigned Q0.15
    function automatic amp_t quarter_sine(input int unsigned j, input int unsigned addr_bits);
        logic [63:0]        x;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        scaled;
        x    = (PIH_Q30 * 64'(j)) >> (addr_bits - 2);
        term = x;
        sum  = signed'(x);
        for (int n = 1; n <= TAYLOR_TERMS; n++)
        begin
            term = (((term * x) >> 30) * x) >> 30;
            term = term / TAYLOR_DIV[n];
            if ((n & 1) == 1)
            begin
                sum = sum - signed'(term);
            end
            else
            begin
                sum = sum + signed'(term);
            end
        end
        if (sum < 0)
        begin
            sum = 64'sd0;
        end
        if (sum > signed'(ONE_Q30))
        begin
            sum = signed'(ONE_Q30);
        end
        scaled = ((64'(sum) * AMP) + (ONE_Q30 >> 1)) >> 30;
        return amp_t'(scaled);
    endfunction

endpackage

// File: rtl/core/nco_complex_mixer.sv
// Channel   Direction  Payload                 Handshake
// cfg       in         cfg_index, cfg_data     cfg_valid / cfg_ready
// smp       in         in_word_t (in_i, in_q)  smp_valid / smp_ready
// mix       out        out_word_t (out_i,q)    mix_valid / mix_ready
//
// One word per cycle sustained while mix_ready holds; a word passes st0, st1, st2, st3 and out.
// Phase update and sine ROM read (two read ports) share the accept cycle.
// Reset clears the phase, both registers and all stage valids; no clearing pass.
// A stalled output fills the bubbles behind it before smp_ready drops.
module nco_complex_mixer #(
    parameter int PHASE_BITS      = 16,
    parameter int TABLE_ADDR_BITS = 10
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  ncm_pkg::cfg_reg_t                  cfg_index,
    input  logic [ncm_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                               smp_valid,
    output logic                               smp_ready,
    input  ncm_pkg::in_word_t                  smp_data,
    output logic                               mix_valid,
    input  logic                               mix_ready,
    output ncm_pkg::out_word_t                 mix_data
);

    localparam int QUARTER  = 1 << (TABLE_ADDR_BITS - 2);
    localparam int ROM_AW   = TABLE_ADDR_BITS - 1;
    localparam int EXT_BITS = (PHASE_BITS > ncm_pkg::STEP_BITS) ? PHASE_BITS
                                                                : ncm_pkg::STEP_BITS;
    localparam int NST      = ncm_pkg::PIPE_DEPTH;

    typedef struct packed {
        logic             en;
        ncm_pkg::sample_t i;
        ncm_pkg::sample_t q;
        logic             sin_neg;
        logic             cos_neg;
    } st0_t;

    typedef struct packed {
        logic             en;
        ncm_pkg::sample_t i;
        ncm_pkg::sample_t q;
        ncm_pkg::prod_t   p_ic;
        ncm_pkg::prod_t   p_qs;
        ncm_pkg::prod_t   p_qc;
        ncm_pkg::prod_t   p_is;
    } st1_t;

    typedef struct packed {
        logic             en;
        ncm_pkg::sample_t i;
        ncm_pkg::sample_t q;
        ncm_pkg::sum_t    sum_i;
        ncm_pkg::sum_t    sum_q;
    } st2_t;

    typedef struct packed {
        logic             en;
        ncm_pkg::sample_t i;
        ncm_pkg::sample_t q;
        logic             neg_i;
        ncm_pkg::mag_t    mag_i;
        logic             neg_q;
        ncm_pkg::mag_t    mag_q;
    } st3_t;

    function automatic ncm_pkg::sample_t scale_sat(input logic neg, input ncm_pkg::mag_t mag);
        logic [63:0]      wide;
        ncm_pkg::quot_t   quot;
        ncm_pkg::sample_t res;
        wide = (64'(mag) << ncm_pkg::RECIP_SHIFT_HI) + (64'(mag) << ncm_pkg::RECIP_SHIFT_LO)
             + (64'(mag) * 64'(ncm_pkg::RECIP_ADD));
        quot = ncm_pkg::quot_t'(wide >> ncm_pkg::RECIP_SHIFT);
        if (neg)
        begin
            if (quot > (ncm_pkg::quot_t'(1) << (ncm_pkg::SAMPLE_BITS - 1)))
            begin
                res = {1'b1, {(ncm_pkg::SAMPLE_BITS - 1){1'b0}}};
            end
            else
            begin
                res = -ncm_pkg::sample_t'(quot);
            end
        end
        else
        begin
            if (quot > ncm_pkg::quot_t'({(ncm_pkg::SAMPLE_BITS - 1){1'b1}}))
            begin
                res = {1'b0, {(ncm_pkg::SAMPLE_BITS - 1){1'b1}}};
            end
            else
            begin
                res = ncm_pkg::sample_t'(quot);
            end
        end
        return res;
    endfunction

    // quarter-wave sine ROM
    ncm_pkg::amp_t sine_rom [QUARTER+1];

    for (genvar g = 0; g <= QUARTER; g++)
    begin : g_rom
        localparam ncm_pkg::amp_t ENTRY = ncm_pkg::quarter_sine(g, TABLE_ADDR_BITS);
        assign sine_rom[g] = ENTRY;
    end

    logic                        mix_en_reg;
    logic signed [ncm_pkg::STEP_BITS-1:0] step_reg;
    logic [PHASE_BITS-1:0]       acc_reg, acc_next;
    logic [EXT_BITS-1:0]         step_ext;
    logic [PHASE_BITS-1:0]       phase_sum;
    logic [TABLE_ADDR_BITS-1:0]  idx;
    logic [1:0]                  quad_s, quad_c;
    logic [TABLE_ADDR_BITS-3:0]  frac;
    logic [ROM_AW-1:0]           sin_addr, cos_addr;
    ncm_pkg::amp_t               sin_mag_reg, cos_mag_reg;
    ncm_pkg::sample_t            sin_val, cos_val;
    logic [NST-1:0]              vld_reg, vld_next, rdy, up_vld;
    logic                        in_acc;
    st0_t                        st0_reg, st0_next;
    st1_t                        st1_reg, st1_next;
    st2_t                        st2_reg, st2_next;
    st3_t                        st3_reg, st3_next;
    ncm_pkg::out_word_t          out_reg, out_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mix_en_reg <= 1'b0;
            step_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                ncm_pkg::REG_MIX_ENABLE: mix_en_reg <= cfg_data[0];
                ncm_pkg::REG_PHASE_STEP: step_reg   <= signed'(cfg_data);
                default:                 mix_en_reg <= mix_en_reg;
            endcase
        end
    end

    // handshake chain
    always_comb
    begin
        rdy[NST-1] = !vld_reg[NST-1] || mix_ready;
        for (int k = NST - 2; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        up_vld   = {vld_reg[NST-2:0], smp_valid};
        vld_next = (rdy & up_vld) | (~rdy & vld_reg);
    end

    assign smp_ready = rdy[0];
    assign in_acc    = smp_valid && rdy[0];
    assign mix_valid = vld_reg[NST-1];
    assign mix_data  = out_reg;

    // phase accumulator and table addressing
    assign step_ext  = EXT_BITS'(step_reg);
    assign phase_sum = acc_reg + step_ext[PHASE_BITS-1:0];
    assign acc_next  = (in_acc && mix_en_reg) ? phase_sum : acc_reg;

    if (PHASE_BITS >= TABLE_ADDR_BITS)
    begin : g_idx_hi
        assign idx = phase_sum[PHASE_BITS-1 -: TABLE_ADDR_BITS];
    end
    else
    begin : g_idx_lo
        assign idx = {phase_sum, (TABLE_ADDR_BITS - PHASE_BITS)'(0)};
    end

    assign quad_s   = idx[TABLE_ADDR_BITS-1 -: 2];
    assign quad_c   = quad_s + 2'd1;
    assign frac     = idx[TABLE_ADDR_BITS-3:0];
    assign sin_addr = quad_s[0] ? (ROM_AW'(QUARTER) - ROM_AW'(frac)) : ROM_AW'(frac);
    assign cos_addr = quad_c[0] ? (ROM_AW'(QUARTER) - ROM_AW'(frac)) : ROM_AW'(frac);

    always_comb
    begin
        st0_next.en      = mix_en_reg;
        st0_next.i       = smp_data.in_i;
        st0_next.q       = smp_data.in_q;
        st0_next.sin_neg = quad_s[1];
        st0_next.cos_neg = quad_c[1];
    end

    // multiply
    assign sin_val = st0_reg.sin_neg ? -ncm_pkg::sample_t'(sin_mag_reg)
                                     : ncm_pkg::sample_t'(sin_mag_reg);
    assign cos_val = st0_reg.cos_neg ? -ncm_pkg::sample_t'(cos_mag_reg)
                                     : ncm_pkg::sample_t'(cos_mag_reg);

    always_comb
    begin
        st1_next.en   = st0_reg.en;
        st1_next.i    = st0_reg.i;
        st1_next.q    = st0_reg.q;
        st1_next.p_ic = st0_reg.i * cos_val;
        st1_next.p_qs = st0_reg.q * sin_val;
        st1_next.p_qc = st0_reg.q * cos_val;
        st1_next.p_is = st0_reg.i * sin_val;
    end

    // combine
    always_comb
    begin
        st2_next.en    = st1_reg.en;
        st2_next.i     = st1_reg.i;
        st2_next.q     = st1_reg.q;
        st2_next.sum_i = ncm_pkg::sum_t'(st1_reg.p_ic) + ncm_pkg::sum_t'(st1_reg.p_qs);
        st2_next.sum_q = ncm_pkg::sum_t'(st1_reg.p_qc) - ncm_pkg::sum_t'(st1_reg.p_is);
    end

    // magnitude
    always_comb
    begin
        st3_next.en    = st2_reg.en;
        st3_next.i     = st2_reg.i;
        st3_next.q     = st2_reg.q;
        st3_next.neg_i = st2_reg.sum_i[ncm_pkg::SUM_BITS-1];
        st3_next.neg_q = st2_reg.sum_q[ncm_pkg::SUM_BITS-1];
        st3_next.mag_i = ncm_pkg::mag_t'(st3_next.neg_i ? -st2_reg.sum_i : st2_reg.sum_i);
        st3_next.mag_q = ncm_pkg::mag_t'(st3_next.neg_q ? -st2_reg.sum_q : st2_reg.sum_q);
    end

    // scale and saturate, or bypass
    always_comb
    begin
        if (st3_reg.en)
        begin
            out_next.out_i = scale_sat(st3_reg.neg_i, st3_reg.mag_i);
            out_next.out_q = scale_sat(st3_reg.neg_q, st3_reg.mag_q);
        end
        else
        begin
            out_next.out_i = st3_reg.i;
            out_next.out_q = st3_reg.q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
            vld_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            st0_reg     <= st0_next;
            sin_mag_reg <= sine_rom[sin_addr];
            cos_mag_reg <= sine_rom[cos_addr];
        end
        if (rdy[1])
        begin
            st1_reg <= st1_next;
        end
        if (rdy[2])
        begin
            st2_reg <= st2_next;
        end
        if (rdy[3])
        begin
            st3_reg <= st3_next;
        end
        if (rdy[4])
        begin
            out_reg <= out_next;
        end
    end

endmodule

// File: rtl/core/ncm_checker.sv
`include "nco_complex_mixer_assert.svh"

module ncm_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               cfg_ready,
    input logic                               smp_valid,
    input logic                               smp_ready,
    input logic                               mix_valid,
    input logic                               mix_ready,
    input ncm_pkg::out_word_t                 mix_data
);

    logic [ncm_pkg::CNT_BITS-1:0] count_reg, count_next;
    logic                         in_acc, out_acc, out_stall;

    assign in_acc    = smp_valid && smp_ready;
    assign out_acc   = mix_valid && mix_ready;
    assign out_stall = mix_valid && !mix_ready;

    // track words in flight
    always_comb
    begin
        count_next = count_reg;
        if (in_acc && !out_acc)
        begin
            count_next = count_reg + ncm_pkg::CNT_BITS'(1);
        end
        else if (out_acc && !in_acc)
        begin
            count_next = count_reg - ncm_pkg::CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    `NCM_ASSERT_ALWAYS(a_reset_idle, !rst_n |-> !mix_valid, "output valid during reset")
    `NCM_ASSERT_ALWAYS(a_cfg_ready, cfg_ready, "config port not ready")
    `NCM_ASSERT(a_out_hold, out_stall |=> mix_valid && $stable(mix_data), "stalled word changed")
    `NCM_ASSERT(a_stall_full, !smp_ready |-> mix_valid, "input stalled with no output pending")
    `NCM_ASSERT(a_no_phantom, mix_valid |-> count_reg != '0, "output word with none in flight")

endmodule

bind nco_complex_mixer ncm_checker u_ncm_checker (.*);
